@@ src/clm_pkg.sv @@
// Package for the lock table engine: default sizes, port field widths and the
// command, reply and message codes. Used by caching_lock_manager; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package clm_pkg;

  // Default table sizes.
  localparam int NUM_LOCKS_DEF   = 64;
  localparam int NUM_CLIENTS_DEF = 16;

  // Fixed widths of the request and result ports.
  localparam int CMD_W    = 1;
  localparam int LOCK_W   = 6;
  localparam int CLIENT_W = 4;
  localparam int REPLY_W  = 2;
  localparam int KIND_W   = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ACQUIRE = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_t;

  typedef enum logic [REPLY_W-1:0] {
    REPLY_GRANTED  = 2'd0,
    REPLY_RETRY    = 2'd1,
    REPLY_RELEASED = 2'd2
  } reply_t;

  typedef enum logic [KIND_W-1:0] {
    MSG_NONE   = 2'd0,
    MSG_REVOKE = 2'd1,
    MSG_RETRY  = 2'd2
  } msg_kind_t;

endpackage : clm_pkg

`default_nettype wire

@@ src/caching_lock_manager.sv @@
// Lock table engine with a FIFO wait list per lock: per-lock table memory,
// wait-slot memory and the request sequencer. Depends on clm_pkg.
`timescale 1ns / 1ps
`default_nettype none

// caching_lock_manager
//
// Takes one request beat (cmd, lock_index, client) when start is high and
// busy is low, and answers it with exactly one result beat: done is high for
// one cycle with reply, msg_kind, msg_client and msg_lock. The receiver cannot
// stall; every result must be taken in the cycle it appears. An acquire of a
// free lock is granted. An acquire of a held lock queues the client (once) on
// the lock's FIFO wait list and replies retry; if the list was empty, a revoke
// message names the current owner. A release frees the lock without checking
// the caller and pops the head waiter, who gets a retry message (the waiter
// is not granted the lock). After reset the block sweeps the lock table to
// clear it and stays busy meanwhile. Then an acquire, or a release with an
// empty wait list, goes from accept to the next accept through table read,
// execute and write, and result; a release that pops a waiter adds a
// wait-slot memory read before the row is written. A lock or client number
// at or above NUM_LOCKS or NUM_CLIENTS is reduced by repeated subtraction,
// one subtraction per cycle, before the table read.
// Messages with msg_kind none carry zero in msg_client and msg_lock.
module caching_lock_manager
  import clm_pkg::*;
#(
  parameter int NUM_LOCKS   = NUM_LOCKS_DEF,
  parameter int NUM_CLIENTS = NUM_CLIENTS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output      logic                busy,
  input  wire logic [CMD_W-1:0]    cmd,
  input  wire logic [LOCK_W-1:0]   lock_index,
  input  wire logic [CLIENT_W-1:0] client,
  output      logic                done,
  output      logic [REPLY_W-1:0]  reply,
  output      logic [KIND_W-1:0]   msg_kind,
  output      logic [CLIENT_W-1:0] msg_client,
  output      logic [LOCK_W-1:0]   msg_lock
);

  localparam int LW    = $clog2(NUM_LOCKS);
  localparam int CW    = $clog2(NUM_CLIENTS);
  localparam int CW1   = CW + 1;
  localparam int CNTW  = $clog2(NUM_CLIENTS + 1);
  localparam int SW    = LW + CW;
  localparam int SLOTS = 2 ** SW;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_REDUCE = 5'b00100,
    S_EXEC   = 5'b01000,
    S_POP    = 5'b10000
  } state_t;

  state_t state, state_next;

  // Request registers.
  logic [CMD_W-1:0]    req_cmd;
  logic [LOCK_W-1:0]   req_lock;
  logic [CLIENT_W-1:0] req_client;
  logic [LW-1:0]       clr_addr;

  // Lock table: one row per lock, split across parallel arrays on one address.
  logic                   held_mem  [NUM_LOCKS];
  logic [CW-1:0]          owner_mem [NUM_LOCKS];
  logic [NUM_CLIENTS-1:0] mark_mem  [NUM_LOCKS];
  logic [CW-1:0]          head_mem  [NUM_LOCKS];
  logic [CNTW-1:0]        count_mem [NUM_LOCKS];

  logic                   held_q;
  logic [CW-1:0]          owner_q;
  logic [NUM_CLIENTS-1:0] mark_q;
  logic [CW-1:0]          head_q;
  logic [CNTW-1:0]        count_q;

  // Wait-slot rings, addressed {lock, ring position}.
  logic [CW-1:0] slot_mem [SLOTS];
  logic [CW-1:0] slot_q;

  // Table and slot port controls.
  logic                   tbl_re;
  logic                   tbl_we;
  logic [LW-1:0]          tbl_wa;
  logic                   wr_held;
  logic [CW-1:0]          wr_owner;
  logic [NUM_CLIENTS-1:0] wr_mark;
  logic [CW-1:0]          wr_head;
  logic [CNTW-1:0]        wr_count;
  logic                   slot_we;
  logic                   slot_re;
  logic [SW-1:0]          slot_addr;

  // Result next values.
  logic                done_next;
  logic [REPLY_W-1:0]  reply_next;
  logic [KIND_W-1:0]   kind_next;
  logic [CLIENT_W-1:0] mclient_next;
  logic [LOCK_W-1:0]   mlock_next;

  // Reduced request fields and the shared ring-position adder.
  logic          lock_ok;
  logic          client_ok;
  logic [LW-1:0] lk;
  logic [CW-1:0] cl;
  logic [CW-1:0] ring_b;
  logic [CW:0]   ring_sum;
  logic [CW-1:0] ring_pos;
  logic          first_ok;

  assign busy      = (state != S_IDLE);
  assign lock_ok   = (32'(req_lock) < NUM_LOCKS);
  assign client_ok = (32'(req_client) < NUM_CLIENTS);
  assign lk        = LW'(req_lock);
  assign cl        = CW'(req_client);
  assign first_ok  = (32'(slot_q) < NUM_CLIENTS);

  // Ring adder: head + count on append, head + 1 on pop; wrap with one subtract.
  assign ring_b   = (state == S_POP) ? CW'(1) : CW'(count_q);
  assign ring_sum = {1'b0, head_q} + {1'b0, ring_b};
  assign ring_pos = (32'(ring_sum) >= NUM_CLIENTS) ? CW'(ring_sum - CW1'(NUM_CLIENTS))
                                                   : CW'(ring_sum);

  always_comb begin
    state_next   = state;
    tbl_re       = 1'b0;
    tbl_we       = 1'b0;
    tbl_wa       = lk;
    wr_held      = held_q;
    wr_owner     = owner_q;
    wr_mark      = mark_q;
    wr_head      = head_q;
    wr_count     = count_q;
    slot_we      = 1'b0;
    slot_re      = 1'b0;
    slot_addr    = {lk, head_q};
    done_next    = 1'b0;
    reply_next   = REPLY_RELEASED;
    kind_next    = MSG_NONE;
    mclient_next = '0;
    mlock_next   = '0;

    unique case (state)
      S_CLEAR: begin
        // Write one zero row per cycle.
        tbl_we   = 1'b1;
        tbl_wa   = clr_addr;
        wr_held  = 1'b0;
        wr_owner = '0;
        wr_mark  = '0;
        wr_head  = '0;
        wr_count = '0;
        if (clr_addr == LW'(NUM_LOCKS - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          state_next = S_REDUCE;
        end
      end

      S_REDUCE: begin
        // Issue the table read once both numbers are in range.
        if (lock_ok && client_ok) begin
          tbl_re     = 1'b1;
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        if (req_cmd == CMD_ACQUIRE) begin
          tbl_we     = 1'b1;
          done_next  = 1'b1;
          state_next = S_IDLE;
          if (!held_q) begin
            wr_held    = 1'b1;
            wr_owner   = cl;
            reply_next = REPLY_GRANTED;
          end else begin
            reply_next = REPLY_RETRY;
            if (!mark_q[cl] && (32'(count_q) < NUM_CLIENTS)) begin
              slot_we     = 1'b1;
              slot_addr   = {lk, ring_pos};
              wr_count    = count_q + CNTW'(1);
              wr_mark[cl] = 1'b1;
            end
            if (count_q == '0) begin
              kind_next    = MSG_REVOKE;
              mclient_next = CLIENT_W'(owner_q);
              mlock_next   = LOCK_W'(lk);
            end
          end
        end else begin
          if (count_q == '0) begin
            tbl_we     = 1'b1;
            wr_held    = 1'b0;
            wr_owner   = '0;
            done_next  = 1'b1;
            state_next = S_IDLE;
          end else begin
            // Fetch the head waiter; the row is written once it is known.
            slot_re    = 1'b1;
            state_next = S_POP;
          end
        end
      end

      S_POP: begin
        tbl_we   = 1'b1;
        wr_held  = 1'b0;
        wr_owner = '0;
        wr_head  = ring_pos;
        wr_count = count_q - CNTW'(1);
        if (first_ok) begin
          wr_mark[slot_q] = 1'b0;
        end
        kind_next    = MSG_RETRY;
        mclient_next = CLIENT_W'(slot_q);
        mlock_next   = LOCK_W'(lk);
        done_next    = 1'b1;
        state_next   = S_IDLE;
      end

      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + LW'(1);
      end
    end
  end

  // Request capture and range reduction.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      req_cmd    <= cmd;
      req_lock   <= lock_index;
      req_client <= client;
    end else if (state == S_REDUCE) begin
      if (!lock_ok) begin
        req_lock <= req_lock - LOCK_W'(NUM_LOCKS);
      end
      if (!client_ok) begin
        req_client <= req_client - CLIENT_W'(NUM_CLIENTS);
      end
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (done_next) begin
      reply      <= reply_next;
      msg_kind   <= kind_next;
      msg_client <= mclient_next;
      msg_lock   <= mlock_next;
    end
  end

  // Lock table memory.
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      held_mem[tbl_wa]  <= wr_held;
      owner_mem[tbl_wa] <= wr_owner;
      mark_mem[tbl_wa]  <= wr_mark;
      head_mem[tbl_wa]  <= wr_head;
      count_mem[tbl_wa] <= wr_count;
    end
    if (tbl_re) begin
      held_q  <= held_mem[lk];
      owner_q <= owner_mem[lk];
      mark_q  <= mark_mem[lk];
      head_q  <= head_mem[lk];
      count_q <= count_mem[lk];
    end
  end

  // Wait-slot memory.
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_addr] <= cl;
    end
    if (slot_re) begin
      slot_q <= slot_mem[slot_addr];
    end
  end

endmodule : caching_lock_manager

`default_nettype wire
